### rtl/core/dht_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the double hashing table engine
// no dependencies

package dht_pkg;

  localparam int SLOTS    = 1024;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int N_W      = IDX_W + 1;
  localparam int KEY_W    = 32;
  localparam int HASH_W   = 32;
  localparam int TSIZE_W  = 11;
  localparam int TOT_W    = 32;

  // remainder unit: bits retired per cycle and steps per remainder
  localparam int REM_BPC   = 4;
  localparam int REM_STEPS = HASH_W / REM_BPC;
  localparam int REM_CNT_W = $clog2(REM_STEPS);

  localparam logic CFG_TABLE_SIZE   = 1'b0;
  localparam logic CFG_EMPTY_MARKER = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_CNTRST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_DONE
  } fsm_t;

endpackage

### rtl/core/dht_rem.sv
`timescale 1ns / 1ps
// radix-16 restoring remainder unit: 32-bit dividend modulo an 11-bit divisor
// depends on dht_pkg

module dht_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [dht_pkg::HASH_W-1:0] dividend_i,
  input  logic [dht_pkg::N_W-1:0]    divisor_i,
  output logic                       done_o,
  output logic [dht_pkg::IDX_W-1:0]  rem_o
);

  logic [dht_pkg::HASH_W-1:0]    quo_r, quo_nxt;
  logic [dht_pkg::N_W-1:0]       div_r;
  logic [dht_pkg::IDX_W-1:0]     rem_r, rem_nxt;
  logic [dht_pkg::REM_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  always_comb begin
    logic [dht_pkg::N_W-1:0]   t;
    logic [dht_pkg::IDX_W-1:0] r;
    r = rem_r;
    for (int j = 0; j < dht_pkg::REM_BPC; j++) begin
      t = {r, quo_r[dht_pkg::HASH_W-1-j]};
      if (t >= div_r) begin
        t = t - div_r;
      end
      r = t[dht_pkg::IDX_W-1:0];
    end
    rem_nxt = r;
    quo_nxt = quo_r << dht_pkg::REM_BPC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == dht_pkg::REM_CNT_W'(dht_pkg::REM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      div_r <= divisor_i;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

### rtl/core/double_hash_table_engine.sv
`timescale 1ns / 1ps
// top level of the double hashing table engine: slot memory, probe sequencer, output register
// depends on dht_pkg and dht_rem

// One request at a time. Insert and search first run the two remainder units (home slot
// and probe step, 4 bits a cycle), then probe the slot memory, which has one write and
// one registered read port, and then hand over the result; probes run from 1 to the
// effective table size. Clear sweeps all 1024 slots one per cycle; the same sweep
// runs after reset, during which no request is taken (configuration writes are).
// The result register lets a new request enter while the last result waits.

module double_hash_table_engine (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // key, first_hash, second_hash
  input  logic [1:0]  in_tuser,   // opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // slot_index, insert_probes, search_probes, zero pad
  output logic [2:0]  out_tuser   // status
);

  localparam int IW = dht_pkg::IDX_W;
  localparam int NW = dht_pkg::N_W;

  logic [dht_pkg::KEY_W-1:0] mem [dht_pkg::SLOTS];
  logic [dht_pkg::KEY_W-1:0] rd_data_r;
  logic [IW-1:0]             rd_addr;
  logic                      mem_we;
  logic [IW-1:0]             mem_wa;
  logic [dht_pkg::KEY_W-1:0] mem_wd;

  dht_pkg::fsm_t state_r, state_nxt;

  logic [dht_pkg::TSIZE_W-1:0] table_size_r;
  logic [dht_pkg::KEY_W-1:0]   empty_marker_r;

  logic [dht_pkg::KEY_W-1:0] fill_r, fill_nxt;
  logic [IW-1:0]             clr_addr_r, clr_addr_nxt;
  logic                      clr_report_r, clr_report_nxt;
  dht_pkg::op_t              op_r, op_nxt;
  logic [dht_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [NW-1:0]             n_r, n_nxt;
  logic [IW-1:0]             step_r, step_nxt;
  logic [IW-1:0]             idx_r, idx_nxt;
  logic [IW-1:0]             k_r, k_nxt;
  logic [dht_pkg::TOT_W-1:0] ins_tot_r, ins_tot_nxt;
  logic [dht_pkg::TOT_W-1:0] srch_tot_r, srch_tot_nxt;
  dht_pkg::status_t          res_status_r, res_status_nxt;
  logic [IW-1:0]             res_slot_r, res_slot_nxt;

  logic                      out_valid_r, out_valid_nxt;
  dht_pkg::status_t          out_status_r;
  logic [IW-1:0]             out_slot_r;
  logic [dht_pkg::TOT_W-1:0] out_ins_r;
  logic [dht_pkg::TOT_W-1:0] out_srch_r;
  logic                      out_load;

  logic [NW-1:0] n_clamp;
  logic          div_start;
  logic          h1_done, h2_done;
  logic [IW-1:0] h1_rem, h2_rem;
  logic [NW-1:0] idx_sum;
  logic [IW-1:0] idx_wrap;
  logic          in_acc;

  // effective table size
  always_comb begin
    if (table_size_r < NW'(2)) begin
      n_clamp = NW'(2);
    end else if (table_size_r > dht_pkg::TSIZE_W'(dht_pkg::SLOTS)) begin
      n_clamp = NW'(dht_pkg::SLOTS);
    end else begin
      n_clamp = NW'(table_size_r);
    end
  end

  dht_rem u_rem_home (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (in_tdata[63:32]),
    .divisor_i  (n_clamp),
    .done_o     (h1_done),
    .rem_o      (h1_rem)
  );

  dht_rem u_rem_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (in_tdata[95:64]),
    .divisor_i  (n_clamp - NW'(1)),
    .done_o     (h2_done),
    .rem_o      (h2_rem)
  );

  // next probe slot, idx and step both below n
  assign idx_sum  = {1'b0, idx_r} + {1'b0, step_r};
  assign idx_wrap = (idx_sum >= n_r) ? IW'(idx_sum - n_r) : idx_sum[IW-1:0];

  assign in_tready = (state_r == dht_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    n_nxt          = n_r;
    step_nxt       = step_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    ins_tot_nxt    = ins_tot_r;
    srch_tot_nxt   = srch_tot_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    div_start      = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = idx_r;
    mem_wd         = key_r;
    rd_addr        = idx_r;
    out_load       = 1'b0;

    unique case (state_r)
      dht_pkg::S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        mem_wd       = fill_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IW'(dht_pkg::SLOTS - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_report_r ? dht_pkg::S_DONE : dht_pkg::S_IDLE;
        end
      end

      dht_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt         = dht_pkg::op_t'(in_tuser);
          key_nxt        = in_tdata[31:0];
          n_nxt          = n_clamp;
          res_status_nxt = dht_pkg::ST_DONE;
          res_slot_nxt   = '0;
          case (dht_pkg::op_t'(in_tuser))
            dht_pkg::OP_INSERT, dht_pkg::OP_SEARCH: begin
              div_start = 1'b1;
              state_nxt = dht_pkg::S_DIV;
            end
            dht_pkg::OP_CLEAR: begin
              fill_nxt       = empty_marker_r;
              clr_report_nxt = 1'b1;
              state_nxt      = dht_pkg::S_CLEAR;
            end
            default: begin
              ins_tot_nxt  = '0;
              srch_tot_nxt = '0;
              state_nxt    = dht_pkg::S_DONE;
            end
          endcase
        end
      end

      dht_pkg::S_DIV: begin
        rd_addr = h1_rem;
        if (h1_done && h2_done) begin
          idx_nxt   = h1_rem;
          step_nxt  = h2_rem + 1'b1;
          k_nxt     = '0;
          state_nxt = dht_pkg::S_CHECK;
        end
      end

      dht_pkg::S_CHECK: begin
        rd_addr = idx_wrap;
        if (rd_data_r == key_r) begin
          res_status_nxt = (op_r == dht_pkg::OP_INSERT) ? dht_pkg::ST_PRESENT
                                                        : dht_pkg::ST_FOUND;
          res_slot_nxt   = idx_r;
          state_nxt      = dht_pkg::S_DONE;
        end else if (rd_data_r == empty_marker_r) begin
          if (op_r == dht_pkg::OP_INSERT) begin
            mem_we         = 1'b1;
            res_status_nxt = dht_pkg::ST_INSERTED;
            res_slot_nxt   = idx_r;
          end else begin
            res_status_nxt = dht_pkg::ST_NOT_FOUND;
          end
          state_nxt = dht_pkg::S_DONE;
        end else begin
          if (k_r != '0) begin
            if (op_r == dht_pkg::OP_INSERT) begin
              ins_tot_nxt = ins_tot_r + 1'b1;
            end else begin
              srch_tot_nxt = srch_tot_r + 1'b1;
            end
          end
          if ({1'b0, k_r} == n_r - NW'(1)) begin
            res_status_nxt = (op_r == dht_pkg::OP_INSERT) ? dht_pkg::ST_FULL
                                                          : dht_pkg::ST_NOT_FOUND;
            state_nxt      = dht_pkg::S_DONE;
          end else begin
            idx_nxt = idx_wrap;
            k_nxt   = k_r + 1'b1;
          end
        end
      end

      dht_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load       = 1'b1;
          clr_report_nxt = 1'b0;
          state_nxt      = dht_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dht_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= dht_pkg::S_CLEAR;
      fill_r         <= '1;
      clr_addr_r     <= '0;
      clr_report_r   <= 1'b0;
      ins_tot_r      <= '0;
      srch_tot_r     <= '0;
      out_valid_r    <= 1'b0;
      table_size_r   <= dht_pkg::TSIZE_W'(1024);
      empty_marker_r <= '1;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      ins_tot_r    <= ins_tot_nxt;
      srch_tot_r   <= srch_tot_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dht_pkg::CFG_TABLE_SIZE:   table_size_r   <= cfg_data[dht_pkg::TSIZE_W-1:0];
          dht_pkg::CFG_EMPTY_MARKER: empty_marker_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    n_r          <= n_nxt;
    step_r       <= step_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_ins_r    <= ins_tot_r;
      out_srch_r   <= srch_tot_r;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_srch_r, out_ins_r, out_slot_r};

endmodule

### verif/dht_result_checker.sv
`timescale 1ns / 1ps
// result checker for the double hashing table engine: mirrors the slot store, probe totals
// and registers from the observed channels and compares every returned result
// depends on dht_pkg

module dht_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // key, first_hash, second_hash
  input  logic [1:0]  in_tuser,   // opcode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,  // slot_index, insert_probes, search_probes, zero pad
  input  logic [2:0]  out_tuser,  // status
  output int          outcomes_open,
  output int          mismatch_count
);

  localparam int INS_LSB  = dht_pkg::IDX_W;
  localparam int SRCH_LSB = dht_pkg::IDX_W + dht_pkg::TOT_W;

  typedef struct packed {
    dht_pkg::status_t            status;
    logic [dht_pkg::IDX_W-1:0]   slot;
    logic [dht_pkg::TOT_W-1:0]   ins_total;
    logic [dht_pkg::TOT_W-1:0]   srch_total;
  } outcome_t;

  logic [dht_pkg::KEY_W-1:0]   slot_mirror [dht_pkg::SLOTS];
  logic [dht_pkg::TOT_W-1:0]   ins_probes;
  logic [dht_pkg::TOT_W-1:0]   srch_probes;
  logic [dht_pkg::TSIZE_W-1:0] size_reg;
  logic [dht_pkg::KEY_W-1:0]   marker_reg;
  outcome_t                    table_outcomes [$];
  int                          errors;

  function automatic outcome_t apply_table_op(dht_pkg::op_t op,
                                             logic [dht_pkg::KEY_W-1:0] key,
                                             logic [dht_pkg::HASH_W-1:0] h1,
                                             logic [dht_pkg::HASH_W-1:0] h2);
    int unsigned n;
    int unsigned step;
    int unsigned pos;
    int unsigned extra;
    int unsigned k;
    logic        matched;
    logic        empty_hit;
    outcome_t    r;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > dht_pkg::SLOTS) n = dht_pkg::SLOTS;
    step = (h2 % (n - 1)) + 1;
    pos = h1 % n;
    extra = 0;
    matched = 1'b0;
    empty_hit = 1'b0;
    r.status = dht_pkg::ST_DONE;
    r.slot = '0;
    if (op == dht_pkg::OP_INSERT || op == dht_pkg::OP_SEARCH) begin
      // key compare comes before the empty check
      for (k = 0; k < n; k++) begin
        if (slot_mirror[pos] == key) begin
          matched = 1'b1;
          break;
        end
        if (slot_mirror[pos] == marker_reg) begin
          empty_hit = 1'b1;
          break;
        end
        if (k > 0) extra++;
        pos = (pos + step) % n;
      end
    end
    case (op)
      dht_pkg::OP_INSERT: begin
        ins_probes += extra;
        if (matched) begin
          r.status = dht_pkg::ST_PRESENT;
          r.slot = pos[dht_pkg::IDX_W-1:0];
        end else if (empty_hit) begin
          slot_mirror[pos] = key;
          r.status = dht_pkg::ST_INSERTED;
          r.slot = pos[dht_pkg::IDX_W-1:0];
        end else begin
          r.status = dht_pkg::ST_FULL;
        end
      end
      dht_pkg::OP_SEARCH: begin
        srch_probes += extra;
        if (matched) begin
          r.status = dht_pkg::ST_FOUND;
          r.slot = pos[dht_pkg::IDX_W-1:0];
        end else begin
          r.status = dht_pkg::ST_NOT_FOUND;
        end
      end
      dht_pkg::OP_CLEAR: begin
        for (k = 0; k < dht_pkg::SLOTS; k++) slot_mirror[k] = marker_reg;
      end
      dht_pkg::OP_CNTRST: begin
        ins_probes = '0;
        srch_probes = '0;
      end
    endcase
    r.ins_total = ins_probes;
    r.srch_total = srch_probes;
    return r;
  endfunction

  always @(posedge clk) begin : track
    outcome_t want;
    outcome_t fresh;
    int       i;
    if (!rst_n) begin
      for (i = 0; i < dht_pkg::SLOTS; i++) slot_mirror[i] = '1;
      ins_probes = '0;
      srch_probes = '0;
      size_reg = dht_pkg::TSIZE_W'(dht_pkg::SLOTS);
      marker_reg = '1;
      table_outcomes.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dht_pkg::CFG_TABLE_SIZE) size_reg = cfg_data[dht_pkg::TSIZE_W-1:0];
        else marker_reg = cfg_data;
      end
      // results first: a request taken this cycle cannot be answered in the same cycle
      if (out_tvalid && out_tready) begin
        if (table_outcomes.size() == 0) begin
          $error("unrequested result: status %0d slot %0d", out_tuser,
                 out_tdata[dht_pkg::IDX_W-1:0]);
          errors++;
        end else begin
          want = table_outcomes.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errors++;
          end
          if (out_tdata[dht_pkg::IDX_W-1:0] !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot,
                   out_tdata[dht_pkg::IDX_W-1:0]);
            errors++;
          end
          if (out_tdata[INS_LSB +: dht_pkg::TOT_W] !== want.ins_total) begin
            $error("insert_probes: expected %0d, got %0d", want.ins_total,
                   out_tdata[INS_LSB +: dht_pkg::TOT_W]);
            errors++;
          end
          if (out_tdata[SRCH_LSB +: dht_pkg::TOT_W] !== want.srch_total) begin
            $error("search_probes: expected %0d, got %0d", want.srch_total,
                   out_tdata[SRCH_LSB +: dht_pkg::TOT_W]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = apply_table_op(dht_pkg::op_t'(in_tuser), in_tdata[31:0],
                               in_tdata[63:32], in_tdata[95:64]);
        table_outcomes = {table_outcomes, fresh};
      end
    end
    outcomes_open <= table_outcomes.size();
    mismatch_count <= errors;
  end

endmodule

### verif/tb_double_hash_table_engine.sv
`timescale 1ns / 1ps
// testbench top for the double hashing table engine: clock, reset, register writes,
// directed and random requests with random idling on both sides, and the verdict
// depends on dht_pkg, double_hash_table_engine and dht_result_checker

module tb_double_hash_table_engine;

  localparam int POOL            = 16;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 57;
  localparam int HOLD_PHASE      = 5;
  localparam int RX_HOLD_CYCLES  = 400;
  localparam int RUN_LIMIT_NS    = 20_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // key, first_hash, second_hash
  logic [1:0]  in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // slot_index, insert_probes, search_probes, zero pad
  logic [2:0]  out_tuser;  // status

  int          outcomes_open;
  int          mismatch_count;

  logic [31:0] pool_key [POOL];
  logic [31:0] pool_h1  [POOL];
  logic [31:0] pool_h2  [POOL];
  logic [31:0] cur_marker;
  bit          tx_calm;
  int          rx_hold_req;
  int          rx_hold_ack;

  double_hash_table_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dht_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .outcomes_open  (outcomes_open),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned roll;
    if (tx_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [10:0] phase_size(int p);
    case (p)
      0:       return 11'd1024;
      1:       return 11'd2;
      2:       return 11'd5;
      3:       return 11'd3;
      4:       return 11'd16;
      5:       return 11'd8;
      6:       return 11'd64;
      7:       return 11'd0;
      8:       return 11'd1023;
      9:       return 11'd4;
      10:      return 11'd2047;
      11:      return 11'd7;
      12:      return 11'd1;
      default: return 11'($urandom_range(2, 200));
    endcase
  endfunction

  task automatic send_req(dht_pkg::op_t op, logic [31:0] key, logic [31:0] h1,
                          logic [31:0] h2);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {h2, h1, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outcomes_open != 0) @(posedge clk);
  endtask

  task automatic load_config(logic [10:0] size, logic [31:0] marker, bit with_marker);
    for (int r = 0; r < 2; r++) begin
      if (r == 0 || with_marker) begin
        cfg_valid <= 1'b1;
        cfg_index <= (r == 0) ? dht_pkg::CFG_TABLE_SIZE : dht_pkg::CFG_EMPTY_MARKER;
        cfg_data  <= (r == 0) ? {21'd0, size} : marker;
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
    if (with_marker) cur_marker = marker;
  endtask

  task automatic send_random_item();
    int unsigned  roll;
    int unsigned  pick;
    dht_pkg::op_t op;
    logic [31:0]  key;
    logic [31:0]  h1;
    logic [31:0]  h2;
    roll = $urandom_range(0, 99);
    if (roll < 46) op = dht_pkg::OP_INSERT;
    else if (roll < 92) op = dht_pkg::OP_SEARCH;
    else if (roll < 96) op = dht_pkg::OP_CNTRST;
    else op = dht_pkg::OP_CLEAR;
    pick = $urandom_range(0, POOL - 1);
    key = pool_key[pick];
    h1 = pool_h1[pick];
    h2 = pool_h2[pick];
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      key = $urandom;
      h1 = $urandom;
      h2 = $urandom;
    end else if (roll < 15) begin
      key = cur_marker;
    end
    send_req(op, key, h1, h2);
  endtask

  // receiver side: random short and long stalls, calm stretches, one long hold-off on request
  initial begin : rx_side
    int idle_left;
    int calm_left;
    int roll;
    idle_left = 0;
    calm_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != rx_hold_ack) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_ack = rx_hold_req;
        out_tready <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_tready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 15) idle_left = $urandom_range(1, 3);
        else if (roll < 17) idle_left = $urandom_range(20, 60);
        else if (roll < 19) calm_left = $urandom_range(100, 300);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] marker;
    bit          marker_write;
    rx_hold_req = 0;
    rx_hold_ack = 0;
    tx_calm = 1'b0;
    cur_marker = '1;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= dht_pkg::CFG_TABLE_SIZE;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= dht_pkg::OP_INSERT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: full size, all-ones marker
    send_req(dht_pkg::OP_SEARCH, 32'd5, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd5, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd5, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd6, 32'd0, 32'd0);
    send_req(dht_pkg::OP_SEARCH, 32'd6, 32'd0, 32'd0);
    send_req(dht_pkg::OP_SEARCH, 32'd8, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd7, 32'd1024, 32'd1022);
    send_req(dht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(dht_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(dht_pkg::OP_INSERT, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_req(dht_pkg::OP_CNTRST, $urandom, $urandom, $urandom);
    send_req(dht_pkg::OP_CLEAR, $urandom, $urandom, $urandom);

    // smallest table: fill it, then overflow and miss
    drain();
    load_config(11'd2, cur_marker, 1'b0);
    send_req(dht_pkg::OP_INSERT, 32'd1, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd2, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd3, 32'd1, 32'd5);
    send_req(dht_pkg::OP_SEARCH, 32'd4, 32'd0, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd1, 32'd0, 32'd0);
    drain();
    load_config(11'd0, cur_marker, 1'b0);
    send_req(dht_pkg::OP_SEARCH, 32'd2, 32'd1, 32'd0);
    drain();
    load_config(11'd1, cur_marker, 1'b0);
    send_req(dht_pkg::OP_INSERT, 32'd9, 32'd0, 32'd0);

    // oversized setting and a marker change without a clear
    drain();
    load_config(11'd2047, 32'd0, 1'b1);
    send_req(dht_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'd5, 32'd0);
    send_req(dht_pkg::OP_INSERT, 32'd0, 32'd5, 32'd3);
    send_req(dht_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    send_req(dht_pkg::OP_CNTRST, $urandom, $urandom, $urandom);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      marker_write = (p % 3 == 0);
      case (p)
        0, 9:    marker = 32'hFFFF_FFFF;
        3:       marker = 32'd0;
        default: marker = $urandom;
      endcase
      load_config(phase_size(p), marker, marker_write);
      for (int i = 0; i < POOL; i++) begin
        pool_key[i] = $urandom;
        pool_h1[i]  = $urandom;
        pool_h2[i]  = $urandom;
      end
      tx_calm = (p % 4 == 1);
      if (p == HOLD_PHASE) begin
        tx_calm = 1'b1;
        rx_hold_req++;
      end
      if (marker_write || $urandom_range(0, 2) == 0) begin
        send_req(dht_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    drain();
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
